FILE: hw/rtl/htsed_pkg.sv
// Shared types, character constants and entity tables for the HTML tag
// stripper / entity decoder. No dependencies; imported by every module.
package htsed_pkg;

  // Input and output beats
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_beat_t;

  // Parser mode codes (6 and 7 never occur and act as text)
  typedef enum logic [2:0] {
    MODE_TEXT      = 3'd0,
    MODE_TAG_START = 3'd1,
    MODE_TAG_PLAIN = 3'd2,
    MODE_SEEK_EQ   = 3'd3,
    MODE_SKIP_SP   = 3'd4,
    MODE_VALUE     = 3'd5
  } mode_t;

  // Entity pattern codes
  localparam logic [1:0] ENT_QUOT = 2'd0;
  localparam logic [1:0] ENT_LT   = 2'd1;
  localparam logic [1:0] ENT_GT   = 2'd2;
  localparam logic [1:0] ENT_AMP  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Longest replay of held entity bytes
  localparam logic [2:0] REPLAY_MAX = 3'd6;

  // Controller states double as the output segment select
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_REPA  = 5'b00010,
    ST_MID   = 5'b00100,
    ST_REPB  = 5'b01000,
    ST_CLOSE = 5'b10000
  } ctl_state_t;

  // Which output segments a byte's plan holds
  typedef struct packed {
    logic rep_a;
    logic mid;
    logic rep_b;
    logic close;
  } seg_flags_t;

  typedef struct packed {
    logic       load;
    logic       beat;
    ctl_state_t seg;
  } htsed_cmd_t;

  typedef struct packed {
    seg_flags_t plan_next;
    seg_flags_t plan;
    logic       seg_end;
  } htsed_sts_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Byte idx of the entity's full text
  function automatic logic [7:0] ent_char(input logic [1:0] pat, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      3'd0: c = CH_AMP;
      3'd1: begin
        case (pat)
          ENT_QUOT: c = CH_Q;
          ENT_LT:   c = CH_L;
          ENT_GT:   c = CH_G;
          default:  c = CH_A;
        endcase
      end
      3'd2: begin
        case (pat)
          ENT_QUOT: c = CH_U;
          ENT_AMP:  c = CH_M;
          default:  c = CH_T;
        endcase
      end
      3'd3: begin
        case (pat)
          ENT_QUOT: c = CH_O;
          ENT_AMP:  c = CH_P;
          default:  c = CH_SEMI;
        endcase
      end
      3'd4: begin
        case (pat)
          ENT_QUOT: c = CH_T;
          ENT_AMP:  c = CH_SEMI;
          default:  c = 8'h00;
        endcase
      end
      3'd5: c = (pat == ENT_QUOT) ? CH_SEMI : 8'h00;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] pat);
    logic [2:0] n;
    case (pat)
      ENT_QUOT: n = 3'd6;
      ENT_AMP:  n = 3'd5;
      default:  n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_val(input logic [1:0] pat);
    logic [7:0] v;
    case (pat)
      ENT_QUOT: v = CH_QUOTE;
      ENT_LT:   v = CH_LT;
      ENT_GT:   v = CH_GT;
      default:  v = CH_AMP;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/htsed_ctrl.sv
// Sequencer for the tag stripper: takes an input beat, then walks the
// output segments of its plan one byte per beat. Depends on htsed_pkg.
module htsed_ctrl
  import htsed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  htsed_sts_t sts,
  output htsed_cmd_t cmd
);

  ctl_state_t state, state_next;

  // First non-empty segment after cur, in emit order
  function automatic ctl_state_t pick_after(input ctl_state_t cur, input seg_flags_t f);
    logic ok_a, ok_m, ok_b, ok_c;
    ctl_state_t s;
    ok_a = (cur == ST_IDLE);
    ok_m = ok_a || (cur == ST_REPA);
    ok_b = ok_m || (cur == ST_MID);
    ok_c = ok_b || (cur == ST_REPB);
    if (ok_a && f.rep_a)      s = ST_REPA;
    else if (ok_m && f.mid)   s = ST_MID;
    else if (ok_b && f.rep_b) s = ST_REPB;
    else if (ok_c && f.close) s = ST_CLOSE;
    else                      s = ST_IDLE;
    return s;
  endfunction

  // Handshake and commands
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state != ST_IDLE);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.beat  = out_valid && out_ready;
  assign cmd.seg   = state;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = pick_after(ST_IDLE, sts.plan_next);
      end
      ST_REPA, ST_MID, ST_REPB, ST_CLOSE: begin
        if (cmd.beat && sts.seg_end) state_next = pick_after(state, sts.plan);
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/htsed_dpath.sv
// Datapath for the tag stripper: parser and entity state, per-byte plan of
// output segments, segment counters and output byte select. Uses htsed_pkg.
module htsed_dpath
  import htsed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  htsed_cmd_t cmd,
  input  in_beat_t   in_data,
  output htsed_sts_t sts,
  output out_beat_t  out_data
);

  // Parser state
  mode_t      mode;
  logic [1:0] pat;
  logic [2:0] len;

  // Plan of the byte being emitted
  logic [1:0] ra_pat, rb_pat;
  logic [2:0] ra_len, rb_len;
  logic [1:0] mid_len;
  logic       mid_open;
  logic [7:0] mid_byte;
  logic       close;
  logic [2:0] seg_cnt;
  logic [4:0] remain;

  // Decode results
  mode_t      mode_next;
  logic [1:0] pat_next, rb_pat_next;
  logic [2:0] len_next, ra_len_next, rb_len_next;
  logic [1:0] mid_len_next;
  logic       mid_open_next, close_next;
  logic [7:0] mid_byte_next;
  logic [4:0] total_next;
  logic       mismatch, text_go;
  logic [7:0] b;
  logic [2:0] seg_len;

  assign b = in_data.in_byte;

  // Per-byte decode: new parser state and output plan
  always_comb begin
    mode_next     = mode;
    pat_next      = pat;
    len_next      = len;
    ra_len_next   = 3'd0;
    rb_len_next   = 3'd0;
    rb_pat_next   = 2'd0;
    mid_len_next  = 2'd0;
    mid_open_next = 1'b0;
    mid_byte_next = b;
    close_next    = 1'b0;
    mismatch      = 1'b0;
    text_go       = 1'b0;
    case (mode)
      MODE_TAG_START: begin
        if (is_space(b)) begin
          mode_next = MODE_TAG_START;
        end else if (b == CH_A || b == CH_UP_A) begin
          mid_len_next  = 2'd2;
          mid_open_next = 1'b1;
          mode_next     = MODE_SEEK_EQ;
        end else if (b == CH_GT) begin
          mode_next = MODE_TEXT;
        end else begin
          mode_next = MODE_TAG_PLAIN;
        end
      end
      MODE_TAG_PLAIN: begin
        if (b == CH_GT) mode_next = MODE_TEXT;
      end
      MODE_SEEK_EQ: begin
        if (b == CH_EQ) begin
          mode_next = MODE_SKIP_SP;
        end else if (b == CH_GT) begin
          close_next = 1'b1;
          mode_next  = MODE_TEXT;
        end
      end
      MODE_SKIP_SP: begin
        if (is_space(b)) begin
          mode_next = MODE_SKIP_SP;
        end else if (b == CH_QUOTE) begin
          mode_next = MODE_VALUE;
        end else if (b == CH_GT) begin
          close_next = 1'b1;
          mode_next  = MODE_TEXT;
        end else begin
          mid_len_next = 2'd1;
          mode_next    = MODE_VALUE;
        end
      end
      MODE_VALUE: begin
        if (is_space(b) || b == CH_QUOTE) begin
          close_next = 1'b1;
          mode_next  = MODE_TAG_PLAIN;
        end else if (b == CH_GT) begin
          close_next = 1'b1;
          mode_next  = MODE_TEXT;
        end else begin
          mid_len_next = 2'd1;
        end
      end
      default: begin
        // Text mode: entity matching first, then plain text handling
        mode_next = MODE_TEXT;
        if (len != 3'd0) begin
          if (len == 3'd1) begin
            if (b == CH_Q) begin
              pat_next = ENT_QUOT;
              len_next = 3'd2;
            end else if (b == CH_L) begin
              pat_next = ENT_LT;
              len_next = 3'd2;
            end else if (b == CH_G) begin
              pat_next = ENT_GT;
              len_next = 3'd2;
            end else if (b == CH_A) begin
              pat_next = ENT_AMP;
              len_next = 3'd2;
            end else begin
              mismatch = 1'b1;
            end
          end else if (len < ent_len(pat) && b == ent_char(pat, len)) begin
            if (len + 3'd1 == ent_len(pat)) begin
              mid_len_next  = 2'd1;
              mid_byte_next = ent_val(pat);
              len_next      = 3'd0;
              pat_next      = 2'd0;
            end else begin
              len_next = len + 3'd1;
            end
          end else begin
            mismatch = 1'b1;
          end
          if (mismatch) begin
            ra_len_next = (len > REPLAY_MAX) ? REPLAY_MAX : len;
            len_next    = 3'd0;
            pat_next    = 2'd0;
            text_go     = 1'b1;
          end
        end else begin
          text_go = 1'b1;
        end
        if (text_go) begin
          if (b == CH_LT) begin
            mode_next = MODE_TAG_START;
          end else if (b == CH_AMP) begin
            len_next = 3'd1;
            pat_next = 2'd0;
          end else if (b != CH_GT) begin
            mid_len_next = 2'd1;
          end
        end
      end
    endcase

    // End of message: flush held entity, close an open link
    if (in_data.end_of_message) begin
      rb_len_next = (len_next > REPLAY_MAX) ? REPLAY_MAX : len_next;
      rb_pat_next = pat_next;
      if (mode_next == MODE_SEEK_EQ || mode_next == MODE_SKIP_SP ||
          mode_next == MODE_VALUE) begin
        close_next = 1'b1;
      end
      mode_next = MODE_TEXT;
      len_next  = 3'd0;
      pat_next  = 2'd0;
    end
  end

  assign total_next = {2'b00, ra_len_next} + {3'b000, mid_len_next} +
                      {2'b00, rb_len_next} + (close_next ? 5'd3 : 5'd0);

  // Segment length of the one being emitted
  always_comb begin
    case (cmd.seg)
      ST_REPA:  seg_len = ra_len;
      ST_MID:   seg_len = {1'b0, mid_len};
      ST_REPB:  seg_len = rb_len;
      ST_CLOSE: seg_len = 3'd3;
      default:  seg_len = 3'd1;
    endcase
  end

  // Status to the controller
  assign sts.plan_next.rep_a = (ra_len_next != 3'd0);
  assign sts.plan_next.mid   = (mid_len_next != 2'd0);
  assign sts.plan_next.rep_b = (rb_len_next != 3'd0);
  assign sts.plan_next.close = close_next;
  assign sts.plan.rep_a      = (ra_len != 3'd0);
  assign sts.plan.mid        = (mid_len != 2'd0);
  assign sts.plan.rep_b      = (rb_len != 3'd0);
  assign sts.plan.close      = close;
  assign sts.seg_end         = (seg_cnt == seg_len - 3'd1);

  // Output byte select
  always_comb begin
    out_data.last_of_run = (remain == 5'd1);
    case (cmd.seg)
      ST_REPA:  out_data.out_byte = ent_char(ra_pat, seg_cnt);
      ST_MID: begin
        if (mid_open) out_data.out_byte = (seg_cnt == 3'd0) ? CH_LBRK : CH_SPACE;
        else          out_data.out_byte = mid_byte;
      end
      ST_REPB:  out_data.out_byte = ent_char(rb_pat, seg_cnt);
      ST_CLOSE: out_data.out_byte = (seg_cnt == 3'd1) ? CH_RBRK : CH_SPACE;
      default:  out_data.out_byte = 8'h00;
    endcase
  end

  // Parser state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_TEXT;
      pat     <= 2'd0;
      len     <= 3'd0;
      seg_cnt <= 3'd0;
      remain  <= 5'd0;
    end else if (cmd.load) begin
      mode    <= mode_next;
      pat     <= pat_next;
      len     <= len_next;
      seg_cnt <= 3'd0;
      remain  <= total_next;
    end else if (cmd.beat) begin
      remain  <= remain - 5'd1;
      seg_cnt <= sts.seg_end ? 3'd0 : seg_cnt + 3'd1;
    end
  end

  // Plan payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ra_pat   <= pat;
      ra_len   <= ra_len_next;
      rb_pat   <= rb_pat_next;
      rb_len   <= rb_len_next;
      mid_len  <= mid_len_next;
      mid_open <= mid_open_next;
      mid_byte <= mid_byte_next;
      close    <= close_next;
    end
  end

endmodule

FILE: hw/rtl/html_tag_strip_entity_decode.sv
// HTML tag stripper and entity decoder. Takes one message byte per input
// beat and gives plain text bytes, one per output beat; last_of_run marks
// the final byte caused by an input byte. The next byte is taken only
// after every output beat of this one has been taken; a byte gives n
// output bytes (n from 0 to 6, usually 1). The controller emits one byte
// per cycle while the receiver is ready and none while it holds off. Tags
// are dropped, links show as "[ value ] ", and the entities &quot; &lt;
// &gt; &amp; decode to one byte each.
module html_tag_strip_entity_decode
  import htsed_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  htsed_cmd_t cmd;
  htsed_sts_t sts;

  // Sequencer
  htsed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Parser and output datapath
  htsed_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: dv/tb.sv
// Testbench for html_tag_strip_entity_decode: drives message bytes through a
// valid/ready beat channel and checks every text beat against a local decoder.
// Depends on htsed_pkg (beat types, character and entity codes) and the RTL.
`timescale 1ns / 100ps

module tb;
  import htsed_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RUN_MAX     = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  html_tag_strip_entity_decode dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state kept by the testbench
  mode_t      pmode = MODE_TEXT;
  logic [1:0] ent_pat = ENT_QUOT;
  logic [2:0] ent_held = 3'd0;
  logic [7:0] run_bytes[$];
  out_beat_t  expected_text[$];

  int n_sent = 0;
  int n_fail = 0;
  int cycle_count = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 22;
  int stall_left = 0;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Full spelling of an entity, left aligned in six byte slots
  function automatic logic [47:0] spelling(input logic [1:0] pat);
    case (pat)
      ENT_QUOT: return "&quot;";
      ENT_LT:   return {"&lt;", 16'h0000};
      ENT_GT:   return {"&gt;", 16'h0000};
      default:  return {"&amp;", 8'h00};
    endcase
  endfunction

  function automatic logic [7:0] ent_letter(input logic [1:0] pat, input int idx);
    logic [47:0] s;
    s = spelling(pat);
    return s[47 - 8 * idx -: 8];
  endfunction

  function automatic int ent_size(input logic [1:0] pat);
    case (pat)
      ENT_QUOT: return 6;
      ENT_AMP:  return 5;
      default:  return 4;
    endcase
  endfunction

  function automatic logic [7:0] ent_value(input logic [1:0] pat);
    case (pat)
      ENT_QUOT: return CH_QUOTE;
      ENT_LT:   return CH_LT;
      ENT_GT:   return CH_GT;
      default:  return CH_AMP;
    endcase
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    if (run_bytes.size() < RUN_MAX) run_bytes.push_back(b);
  endfunction

  function automatic void put_close();
    put_byte(CH_SPACE);
    put_byte(CH_RBRK);
    put_byte(CH_SPACE);
  endfunction

  // Ordinary byte outside a tag
  function automatic void plain_text(input logic [7:0] b);
    if (b == CH_LT) begin
      pmode = MODE_TAG_START;
    end else if (b == CH_AMP) begin
      ent_held = 3'd1;
      ent_pat = ENT_QUOT;
    end else if (b != CH_GT) begin
      put_byte(b);
    end
  endfunction

  // Held '&' and partial entity go out as text
  function automatic void replay_held();
    for (int i = 0; i < ent_held && i < 6; i++) put_byte(ent_letter(ent_pat, i));
    ent_held = 3'd0;
    ent_pat = ENT_QUOT;
  endfunction

  function automatic void entity_char(input logic [7:0] b);
    logic [1:0] cand;
    logic       hit;
    cand = ENT_QUOT;
    hit = 1'b1;
    if (ent_held == 3'd1) begin
      case (b)
        CH_Q:    cand = ENT_QUOT;
        CH_L:    cand = ENT_LT;
        CH_G:    cand = ENT_GT;
        CH_A:    cand = ENT_AMP;
        default: hit = 1'b0;
      endcase
      if (hit) begin
        ent_pat = cand;
        ent_held = 3'd2;
        return;
      end
    end else if (b == ent_letter(ent_pat, ent_held)) begin
      if (ent_held + 1 == ent_size(ent_pat)) begin
        put_byte(ent_value(ent_pat));
        ent_held = 3'd0;
        ent_pat = ENT_QUOT;
      end else begin
        ent_held = ent_held + 3'd1;
      end
      return;
    end
    replay_held();
    plain_text(b);
  endfunction

  // Works out the text beats one accepted message byte causes
  function automatic void decode_byte(input logic [7:0] b, input logic eom);
    out_beat_t e;
    run_bytes.delete();
    case (pmode)
      MODE_TAG_START: begin
        if (!is_blank(b)) begin
          if (b == CH_A || b == CH_UP_A) begin
            put_byte(CH_LBRK);
            put_byte(CH_SPACE);
            pmode = MODE_SEEK_EQ;
          end else if (b == CH_GT) begin
            pmode = MODE_TEXT;
          end else begin
            pmode = MODE_TAG_PLAIN;
          end
        end
      end
      MODE_TAG_PLAIN: begin
        if (b == CH_GT) pmode = MODE_TEXT;
      end
      MODE_SEEK_EQ: begin
        if (b == CH_EQ) begin
          pmode = MODE_SKIP_SP;
        end else if (b == CH_GT) begin
          put_close();
          pmode = MODE_TEXT;
        end
      end
      MODE_SKIP_SP: begin
        if (!is_blank(b)) begin
          if (b == CH_QUOTE) begin
            pmode = MODE_VALUE;
          end else if (b == CH_GT) begin
            put_close();
            pmode = MODE_TEXT;
          end else begin
            put_byte(b);
            pmode = MODE_VALUE;
          end
        end
      end
      MODE_VALUE: begin
        if (is_blank(b) || b == CH_QUOTE) begin
          put_close();
          pmode = MODE_TAG_PLAIN;
        end else if (b == CH_GT) begin
          put_close();
          pmode = MODE_TEXT;
        end else begin
          put_byte(b);
        end
      end
      default: begin
        pmode = MODE_TEXT;
        if (ent_held != 3'd0) entity_char(b);
        else plain_text(b);
      end
    endcase

    // End of message: flush held entity, close an open link
    if (eom) begin
      if (ent_held != 3'd0) replay_held();
      if (pmode == MODE_SEEK_EQ || pmode == MODE_SKIP_SP || pmode == MODE_VALUE)
        put_close();
      pmode = MODE_TEXT;
      ent_held = 3'd0;
      ent_pat = ENT_QUOT;
    end

    for (int i = 0; i < run_bytes.size(); i++) begin
      e.out_byte = run_bytes[i];
      e.last_of_run = (i == run_bytes.size() - 1);
      expected_text.push_back(e);
    end
  endfunction

  // One input beat; idles first at random, predicts once accepted
  task automatic send_byte(input logic [7:0] b, input logic eom);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, eom};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, eom);
    n_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_string(input string s, input logic eom_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eom_last && (i == s.len() - 1));
  endtask

  function automatic logic rand_eom();
    return $urandom_range(39) == 0;
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(1) == 0) return CH_SPACE;
    return 8'($urandom_range(8'h0D, 8'h09));
  endfunction

  function automatic logic [7:0] letter_char();
    if ($urandom_range(3) == 0) return 8'($urandom_range(8'h5A, 8'h41));
    return 8'($urandom_range(8'h7A, 8'h61));
  endfunction

  // Tag body filler: anything but '>'
  function automatic logic [7:0] soup_char();
    logic [7:0] c;
    case ($urandom_range(5))
      0: begin
        c = 8'($urandom_range(255));
        if (c == CH_GT) c = CH_AMP;
      end
      1: c = CH_AMP;
      2: c = CH_LT;
      3: c = CH_EQ;
      4: c = CH_QUOTE;
      default: c = letter_char();
    endcase
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    case ($urandom_range(7))
      0: return CH_AMP;
      1: return CH_LT;
      2: return 8'h2F;
      3: return 8'($urandom_range(8'h39, 8'h30));
      default: return letter_char();
    endcase
  endfunction

  // Mostly well-formed text, entities, tags and links with random content
  task automatic send_fragment();
    int         kind;
    int         n;
    int         cut;
    logic [1:0] pat;
    logic [7:0] term;
    kind = $urandom_range(15);
    pat = 2'($urandom_range(3));
    case (kind)
      0, 1: send_byte(8'($urandom_range(255)), rand_eom());
      2, 3, 4: begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte(letter_char(), rand_eom());
      end
      5, 6: begin
        for (int i = 0; i < ent_size(pat); i++) send_byte(ent_letter(pat, i), rand_eom());
      end
      7, 8: begin
        // partial entity, then an end flag or a following byte that may break or complete it
        cut = $urandom_range(ent_size(pat) - 1, 1);
        for (int i = 0; i < cut; i++)
          send_byte(ent_letter(pat, i), (i == cut - 1) && ($urandom_range(3) == 0));
        case ($urandom_range(4))
          0: send_byte(CH_AMP, 1'b0);
          1: send_byte(CH_LT, 1'b0);
          2: send_byte(CH_SEMI, rand_eom());
          3: send_byte(letter_char(), rand_eom());
          default: send_byte(8'($urandom_range(255)), rand_eom());
        endcase
      end
      9, 10: begin
        send_byte(CH_LT, 1'b0);
        n = $urandom_range(2);
        repeat (n) send_byte(blank_char(), rand_eom());
        send_byte(8'($urandom_range(8'h7A, 8'h62)), rand_eom());
        n = $urandom_range(5);
        repeat (n) send_byte(soup_char(), rand_eom());
        send_byte(CH_GT, rand_eom());
      end
      11, 12, 13: begin
        send_byte(CH_LT, 1'b0);
        n = $urandom_range(2);
        repeat (n) send_byte(blank_char(), rand_eom());
        send_byte($urandom_range(1) ? CH_A : CH_UP_A, rand_eom());
        n = $urandom_range(3);
        repeat (n) send_byte($urandom_range(1) ? CH_SPACE : letter_char(), rand_eom());
        if ($urandom_range(7) == 0) begin
          send_byte(CH_GT, rand_eom());
          return;
        end
        send_byte(CH_EQ, rand_eom());
        n = $urandom_range(2);
        repeat (n) send_byte(blank_char(), rand_eom());
        if ($urandom_range(1)) send_byte(CH_QUOTE, rand_eom());
        n = $urandom_range(5);
        repeat (n) send_byte(value_char(), rand_eom());
        case ($urandom_range(2))
          0: term = CH_QUOTE;
          1: term = blank_char();
          default: term = CH_GT;
        endcase
        send_byte(term, rand_eom());
        if (term != CH_GT) begin
          n = $urandom_range(3);
          repeat (n) send_byte(soup_char(), rand_eom());
          send_byte(CH_GT, rand_eom());
        end
      end
      14: begin
        if ($urandom_range(1)) send_byte(CH_LT, 1'b0);
        send_byte(CH_GT, rand_eom());
      end
      default: send_byte(blank_char(), rand_eom());
    endcase
  endtask

  task automatic run_mix(input int count);
    int goal;
    goal = n_sent + count;
    while (n_sent < goal) send_fragment();
  endtask

  // Tests
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_string("&quo>", 1'b0);       // broken quot replayed, stray '>' dropped
    send_string("<a=\"x\" &>", 1'b0); // quoted link value, '&' inside tag dropped
    send_string("< A>", 1'b0);        // link tag closed before any '='
    send_string("&am", 1'b1);         // held entity flushed by end flag
    send_string("<a= y", 1'b1);       // link still open at end of message
    idle_input();
  endtask

  task automatic test_random_text();
    run_mix(220);
    idle_input();
  endtask

  task automatic test_stalled_receiver();
    stall_left = 300;
    run_mix(40);
    idle_input();
  endtask

  task automatic test_steady_stream();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mix(80);
    send_idle_pct = 22;
    recv_idle_pct = 22;
    idle_input();
  endtask

  task automatic test_random_tail();
    run_mix(90);
    idle_input();
  endtask

  // Receiver: random idling plus an occasional long hold-off
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each output beat with the oldest expected text beat
  out_beat_t oldest;
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected output beat: out_byte %h last_of_run %b",
               out_data.out_byte, out_data.last_of_run);
        n_fail++;
      end else begin
        oldest = expected_text.pop_front();
        if (out_data.out_byte !== oldest.out_byte) begin
          $error("out_byte: expected %h, got %h", oldest.out_byte, out_data.out_byte);
          n_fail++;
        end
        if (out_data.last_of_run !== oldest.last_of_run) begin
          $error("last_of_run: expected %b, got %b", oldest.last_of_run,
                 out_data.last_of_run);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_text();
    test_stalled_receiver();
    test_steady_stream();
    test_random_tail();
    while (expected_text.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && expected_text.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
